FILE: src/bfm3_pkg.sv
package bfm3_pkg;

	// MurmurHash3 x86_32 constants.
	localparam logic [31:0] MH_C1 = 32'hcc9e2d51;
	localparam logic [31:0] MH_C2 = 32'h1b873593;
	localparam logic [31:0] MH_N  = 32'he6546b64;
	localparam logic [31:0] MH_F1 = 32'h85ebca6b;
	localparam logic [31:0] MH_F2 = 32'hc2b2ae35;

	// Configuration register indexes.
	localparam logic REG_FILTER_BITS = 1'b0;
	localparam logic REG_HASH_COUNT  = 1'b1;

	// Operation codes.
	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [2:0] {
		F_IDLE,
		F_MUL1,
		F_MUL2,
		F_APPLY,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_MIX1,
		B_MIX2,
		B_MIX3,
		B_MOD,
		B_READ,
		B_UPD
	} back_state_t;

	function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
		rotl32 = (x << r) | (x >> (32 - r));
	endfunction

endpackage

FILE: src/bfm3_queue.sv
module bfm3_queue #(
	parameter int W = 257
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	output logic         q_full,
	input  logic         rd_en,
	output logic [W-1:0] rd_data,
	output logic         q_empty
);
	// Two-entry queue between the front and the back.
	logic [W-1:0] slot_q [2];
	logic         wptr_q;
	logic         rptr_q;
	logic [1:0]   count_q;

	assign q_full  = (count_q == 2'd2);
	assign q_empty = (count_q == 2'd0);
	assign rd_data = slot_q[rptr_q];

	// Payload slots.
	always_ff @(posedge clk) begin
		if (wr_en && !q_full) begin
			slot_q[wptr_q] <= wr_data;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (wr_en && !q_full) begin
				wptr_q <= ~wptr_q;
			end
			if (rd_en && !q_empty) begin
				rptr_q <= ~rptr_q;
			end
			case ({wr_en && !q_full, rd_en && !q_empty})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("queue count out of range");
	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0 || count_q == 2'd2) |-> (wptr_q == rptr_q))
		else $error("queue pointers disagree with count");
	a_one_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd1) |-> (wptr_q != rptr_q))
		else $error("queue pointers disagree with count");
endmodule

FILE: src/bfm3_front.sv
module bfm3_front #(
	parameter int MAX_HASHES = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic                       op,
	input  logic [7:0]                 key_byte,
	input  logic                       byte_valid,
	input  logic                       last,
	input  logic                       clear_busy,
	input  logic                       q_full,
	output logic                       q_push,
	output logic [MAX_HASHES*32:0]     q_data
);
	import bfm3_pkg::*;

	front_state_t state_q, state_d;

	logic [31:0] lane_q   [MAX_HASHES];
	logic [31:0] lane_mix [MAX_HASHES];
	logic [31:0] fin_d    [MAX_HASHES];
	logic [31:0] fin_q    [MAX_HASHES];
	logic [31:0] blk_q;
	logic [1:0]  fill_q;
	logic [31:0] len_q;
	logic [31:0] sc_in_q;
	logic [31:0] m1_q;
	logic [31:0] m2_q;
	logic        tail_q;
	logic        last_q;
	logic        op_q;
	logic        accept;
	logic [31:0] blk_new;

	assign accept  = push && !full;
	assign blk_new = blk_q | (32'(key_byte) << {fill_q, 3'b000});

	// Block mix of every lane and the finalizer input.
	always_comb begin
		for (int i = 0; i < MAX_HASHES; i++) begin
			lane_mix[i] = rotl32(lane_q[i] ^ m2_q, 13);
			lane_mix[i] = (lane_mix[i] << 2) + lane_mix[i] + MH_N;
			if (state_q == F_IDLE) begin
				fin_d[i] = lane_q[i] ^ len_q;
			end else if (tail_q) begin
				fin_d[i] = lane_q[i] ^ m2_q ^ len_q;
			end else begin
				fin_d[i] = lane_mix[i] ^ len_q;
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: begin
				if (accept) begin
					if (byte_valid) begin
						state_d = F_MUL1;
						if (fill_q != 2'd3 && !last) begin
							state_d = F_IDLE;
						end
					end else if (last) begin
						state_d = (fill_q != 2'd0) ? F_MUL1 : F_PUSH;
					end
				end
			end
			F_MUL1:  state_d = F_MUL2;
			F_MUL2:  state_d = F_APPLY;
			F_APPLY: state_d = (tail_q || last_q) ? F_PUSH : F_IDLE;
			F_PUSH:  state_d = q_full ? F_PUSH : F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		full   = (state_q != F_IDLE) || clear_busy;
		q_push = (state_q == F_PUSH) && !q_full;
		q_data[MAX_HASHES*32] = op_q;
		for (int i = 0; i < MAX_HASHES; i++) begin
			q_data[i*32 +: 32] = fin_q[i];
		end
	end

	// Final lane values wait here for queue space.
	always_ff @(posedge clk) begin
		if ((state_q == F_IDLE) || (state_q == F_APPLY)) begin
			for (int i = 0; i < MAX_HASHES; i++) begin
				fin_q[i] <= fin_d[i];
			end
		end
		if (state_q == F_MUL1) begin
			m1_q <= sc_in_q * MH_C1;
		end
		if (state_q == F_MUL2) begin
			m2_q <= rotl32(m1_q, 15) * MH_C2;
		end
	end

	// Key accumulation state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			for (int i = 0; i < MAX_HASHES; i++) begin
				lane_q[i] <= 32'(i);
			end
			blk_q   <= '0;
			fill_q  <= '0;
			len_q   <= '0;
			sc_in_q <= '0;
			tail_q  <= 1'b0;
			last_q  <= 1'b0;
			op_q    <= OP_ADD;
		end else begin
			state_q <= state_d;
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						op_q   <= op;
						last_q <= last;
						if (byte_valid) begin
							blk_q   <= blk_new;
							fill_q  <= fill_q + 2'd1;
							len_q   <= len_q + 32'd1;
							sc_in_q <= blk_new;
							tail_q  <= (fill_q != 2'd3);
						end else if (last) begin
							// A byteless end of key still scrambles the tail.
							sc_in_q <= blk_q;
							tail_q  <= 1'b1;
						end
					end
				end
				F_APPLY: begin
					if (!tail_q) begin
						for (int i = 0; i < MAX_HASHES; i++) begin
							lane_q[i] <= lane_mix[i];
						end
						blk_q <= '0;
					end
				end
				F_PUSH: begin
					if (!q_full) begin
						for (int i = 0; i < MAX_HASHES; i++) begin
							lane_q[i] <= 32'(i);
						end
						blk_q  <= '0;
						fill_q <= '0;
						len_q  <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	a_full_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != F_IDLE) |-> full) else $error("front accepts while busy");
	a_push_state: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (state_q == F_PUSH && !q_full)) else $error("bad queue push");
	a_apply_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_APPLY) |-> ($past(state_q) == F_MUL2))
		else $error("apply without multiply");
endmodule

FILE: src/bfm3_back.sv
module bfm3_back #(
	parameter int MAX_BITS   = 65536,
	parameter int MAX_HASHES = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [16:0]            filter_bits,
	input  logic [3:0]             hash_count,
	input  logic                   q_empty,
	input  logic [MAX_HASHES*32:0] q_data,
	output logic                   q_pop,
	output logic                   clear_busy,
	output logic                   res_valid,
	output logic                   res_present,
	input  logic                   res_pop
);
	import bfm3_pkg::*;

	localparam int NW   = $clog2(MAX_BITS) + 1;
	localparam int ROWS = (MAX_BITS + 31) / 32;
	localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int LW   = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;

	back_state_t state_q, state_d;

	logic [31:0]            mem [ROWS];
	logic [31:0]            rd_q;
	logic [MAX_HASHES*32-1:0] entry_q;
	logic                   op_q;
	logic [LW-1:0]          lane_q;
	logic [31:0]            x_q;
	logic [31:0]            hv_q;
	logic [NW-1:0]          rem_q;
	logic [4:0]             step_q;
	logic                   all_q;
	logic [RW-1:0]          clr_q;
	logic                   res_valid_q;
	logic                   res_present_q;
	logic [31:0]            fb32;
	logic [NW-1:0]          nbits;
	logic [4:0]             hc5;
	logic [4:0]             nh_m1;
	logic [31:0]            h_sel;
	logic [NW:0]            trial;
	logic [31:0]            posx;
	logic [RW-1:0]          row;
	logic                   bit_set;
	logic                   last_lane;
	logic                   we;
	logic [RW-1:0]          wa;
	logic [31:0]            wd;

	// Clamp the configuration to the supported ranges.
	always_comb begin
		fb32 = 32'(filter_bits);
		if (fb32 == 32'd0) begin
			nbits = NW'(1);
		end else if (fb32 > 32'(MAX_BITS)) begin
			nbits = NW'(MAX_BITS);
		end else begin
			nbits = NW'(fb32);
		end
		hc5 = {1'b0, hash_count};
		if (hc5 == 5'd0) begin
			nh_m1 = 5'd0;
		end else if (hc5 > 5'(MAX_HASHES)) begin
			nh_m1 = 5'(MAX_HASHES - 1);
		end else begin
			nh_m1 = hc5 - 5'd1;
		end
	end

	assign h_sel     = entry_q[lane_q*32 +: 32];
	assign trial     = {rem_q, hv_q[31]};
	assign posx      = 32'(rem_q);
	assign row       = posx[5 +: RW];
	assign bit_set   = rd_q[posx[4:0]];
	assign last_lane = (5'(lane_q) == nh_m1);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_CLEAR: state_d = (clr_q == RW'(ROWS - 1)) ? B_IDLE : B_CLEAR;
			B_IDLE:  state_d = q_empty ? B_IDLE : B_MIX1;
			B_MIX1:  state_d = B_MIX2;
			B_MIX2:  state_d = B_MIX3;
			B_MIX3:  state_d = B_MOD;
			B_MOD:   state_d = (step_q == 5'd0) ? B_READ : B_MOD;
			B_READ:  state_d = B_UPD;
			B_UPD: begin
				if (!last_lane) begin
					state_d = B_MIX1;
				end else if (op_q == OP_ADD || !res_valid_q || res_pop) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// Outputs and memory write port.
	always_comb begin
		clear_busy = (state_q == B_CLEAR);
		q_pop      = (state_q == B_IDLE) && !q_empty;
		we         = 1'b0;
		wa         = row;
		wd         = rd_q | (32'd1 << posx[4:0]);
		if (state_q == B_CLEAR) begin
			we = 1'b1;
			wa = clr_q;
			wd = '0;
		end else if (state_q == B_UPD && op_q == OP_ADD) begin
			we = 1'b1;
		end
		res_valid   = res_valid_q;
		res_present = res_present_q;
	end

	// Bit store, one 32-bit row per access.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[row];
	end

	// Finalizer and remainder datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				entry_q <= q_data[MAX_HASHES*32-1:0];
			end
			B_MIX1: x_q <= (h_sel ^ (h_sel >> 16)) * MH_F1;
			B_MIX2: x_q <= (x_q ^ (x_q >> 13)) * MH_F2;
			B_MIX3: begin
				hv_q  <= x_q ^ (x_q >> 16);
				rem_q <= '0;
			end
			B_MOD: begin
				hv_q <= hv_q << 1;
				if (trial >= {1'b0, nbits}) begin
					rem_q <= NW'(trial - {1'b0, nbits});
				end else begin
					rem_q <= NW'(trial);
				end
			end
			default: begin
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= B_CLEAR;
			clr_q         <= '0;
			lane_q        <= '0;
			step_q        <= '0;
			op_q          <= OP_ADD;
			all_q         <= 1'b1;
			res_valid_q   <= 1'b0;
			res_present_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				B_CLEAR: clr_q <= clr_q + RW'(1);
				B_IDLE: begin
					if (!q_empty) begin
						op_q   <= q_data[MAX_HASHES*32];
						lane_q <= '0;
						all_q  <= 1'b1;
					end
				end
				B_MIX3: step_q <= 5'd31;
				B_MOD:  step_q <= step_q - 5'd1;
				B_UPD: begin
					if (!last_lane) begin
						lane_q <= lane_q + LW'(1);
						all_q  <= all_q & bit_set;
					end else if (op_q == OP_QUERY && state_d == B_IDLE) begin
						res_valid_q   <= 1'b1;
						res_present_q <= all_q & bit_set;
					end
				end
				default: begin
				end
			endcase
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_READ) |-> (rem_q < nbits)) else $error("bit position out of range");
	a_add_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_UPD && op_q == OP_ADD) |=> !$rose(res_valid_q))
		else $error("add produced a result");
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (state_q == B_MIX1)) else $error("pop outside idle");
	a_no_clear_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_CLEAR) |-> !q_pop) else $error("item taken during clear");
endmodule

FILE: src/bloom_filter_murmur3.sv
// Channel  | Ports                                   | Handshake
// -------- | --------------------------------------- | ---------------------------
// input    | op, key_byte, byte_valid, last          | push && !full
// result   | present                                 | pop && !empty
// config   | psel, penable, pwrite, paddr, pwdata    | psel && penable && pwrite
//
// A byte item that completes a 4-byte block, or ends a key with a tail
// pending, holds full high while the front runs its two multiplies; other
// byte items leave full low. The last item of a key ends with a push into the
// two-entry queue. For each hash the back runs two multiplies, a 32-step
// remainder, a read of the bit store and, for an add, a write. After reset the
// bit store is cleared one 32-bit row a cycle, with full held high.
module bloom_filter_murmur3 #(
	parameter int MAX_BITS   = 65536,
	parameter int MAX_HASHES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        op,
	input  logic [7:0]  key_byte,
	input  logic        byte_valid,
	input  logic        last,
	output logic        empty,
	input  logic        pop,
	output logic        present,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import bfm3_pkg::*;

	logic [16:0]            filter_bits_q;
	logic [3:0]             hash_count_q;
	logic                   cfg_wr;
	logic                   clear_busy;
	logic                   q_full;
	logic                   q_empty;
	logic                   q_push;
	logic                   q_pop;
	logic [MAX_HASHES*32:0] q_wdata;
	logic [MAX_HASHES*32:0] q_rdata;
	logic                   res_valid;

	// Configuration registers.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[1:0] == 2'b00);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_bits_q <= 17'd1000;
			hash_count_q  <= 4'd7;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_FILTER_BITS: filter_bits_q <= pwdata[16:0];
				REG_HASH_COUNT:  hash_count_q  <= pwdata[3:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_FILTER_BITS: prdata = 32'(filter_bits_q);
			REG_HASH_COUNT:  prdata = 32'(hash_count_q);
			default:         prdata = '0;
		endcase
	end

	// Front: byte packing and lane mixing.
	bfm3_front #(.MAX_HASHES(MAX_HASHES)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.op         (op),
		.key_byte   (key_byte),
		.byte_valid (byte_valid),
		.last       (last),
		.clear_busy (clear_busy),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_wdata)
	);

	// Queue of finished keys.
	bfm3_queue #(.W(MAX_HASHES * 32 + 1)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wdata),
		.q_full  (q_full),
		.rd_en   (q_pop),
		.rd_data (q_rdata),
		.q_empty (q_empty)
	);

	// Back: finalizer, remainder and bit store.
	bfm3_back #(.MAX_BITS(MAX_BITS), .MAX_HASHES(MAX_HASHES)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.filter_bits (filter_bits_q),
		.hash_count  (hash_count_q),
		.q_empty     (q_empty),
		.q_data      (q_rdata),
		.q_pop       (q_pop),
		.clear_busy  (clear_busy),
		.res_valid   (res_valid),
		.res_present (present),
		.res_pop     (pop)
	);

	assign empty = !res_valid;
endmodule
